FILE: src/bimodal_gshare_branch_predictor_top_macros.svh
// assertion macros shared by the predictor modules
// each macro expects i_clk and i_rst_n in the enclosing module
`ifndef BIMODAL_GSHARE_BRANCH_PREDICTOR_TOP_MACROS_SVH
`define BIMODAL_GSHARE_BRANCH_PREDICTOR_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BGP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BGP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bgp_pkg.sv
// types, constants and helpers shared by the branch predictor modules
// no dependencies
package bgp_pkg;

    localparam int MAX_INDEX_BITS = 14;
    localparam int IDX_W          = MAX_INDEX_BITS;
    localparam int TABLE_DEPTH    = 1 << IDX_W;
    localparam int CFG_W          = 4;
    localparam int CFG_IDX_W      = 1;
    localparam int ADDR_W         = 32;
    localparam int CNT_W          = 32;
    localparam int CTR_W          = 2;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CTR_W-1:0] t_ctr;
    typedef logic [CFG_W-1:0] t_cfg;

    localparam t_ctr CTR_WEAK_TAKEN = 2'd2;
    localparam t_ctr CTR_MAX        = 2'd3;
    localparam t_cfg INDEX_BITS_RST = (MAX_INDEX_BITS < 14) ? CFG_W'(MAX_INDEX_BITS) : 4'd14;
    localparam t_cfg HIST_BITS_RST  = 4'd0;
    localparam t_cfg MAX_M          = CFG_W'(MAX_INDEX_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INDEX_BITS   = 1'b0,
        REG_HISTORY_BITS = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [ADDR_W-1:0] branch_address;
        logic              taken;
    } t_branch;

    typedef struct packed {
        logic             predicted_taken;
        logic             mispredicted;
        t_idx             table_index;
        logic [CNT_W-1:0] prediction_count;
        logic [CNT_W-1:0] miss_count;
    } t_result;

    // one classified branch handed from front to back
    typedef struct packed {
        t_idx idx;
        logic taken;
    } t_req;

    // front-facing status of the queue and back end
    typedef struct packed {
        logic q_full;
        logic clearing;
    } t_back_status;

    function automatic t_idx low_mask(input t_cfg k);
        return ~(t_idx'({IDX_W{1'b1}}) << k);
    endfunction

endpackage

FILE: src/bgp_front.sv
// front end: config registers, index hashing and global history
// depends on bgp_pkg
module bgp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bgp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  bgp_pkg::t_cfg                 i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  bgp_pkg::t_branch              i_branch,
    input  bgp_pkg::t_back_status         i_status,
    output logic                          o_push,
    output bgp_pkg::t_req                 o_req
);
    import bgp_pkg::*;

    t_cfg r_index_bits;
    t_cfg r_history_bits;
    t_idx r_hist;
    t_idx n_hist;

    t_cfg m_eff;
    t_cfg n_eff;
    t_cfg shift;
    t_idx hmask;
    t_idx addr_index;
    t_idx taken_bit;
    logic accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits   <= INDEX_BITS_RST;
            r_history_bits <= HIST_BITS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_INDEX_BITS:   r_index_bits   <= i_cfg_data;
                REG_HISTORY_BITS: r_history_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        m_eff      = (r_index_bits > MAX_M) ? MAX_M : r_index_bits;
        n_eff      = (r_history_bits > m_eff) ? m_eff : r_history_bits;
        shift      = m_eff - n_eff;
        hmask      = low_mask(n_eff);
        addr_index = i_branch.branch_address[IDX_W+1:2] & low_mask(m_eff);
        // history lands on the top n of the m index bits
        o_req.idx   = addr_index ^ ((r_hist & hmask) << shift);
        o_req.taken = i_branch.taken;
        taken_bit = t_idx'(i_branch.taken) << (n_eff - t_cfg'(1));
        if (n_eff != '0) begin
            n_hist = (((r_hist & hmask) >> 1) | taken_bit) & hmask;
        end else begin
            n_hist = r_hist;
        end
    end

    assign o_ready = !i_status.q_full && !i_status.clearing;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (accept) begin
            r_hist <= n_hist;
        end
    end

endmodule

FILE: src/bgp_queue.sv
// short queue of classified branches between front and back end
// depends on bgp_pkg and the assertion macro header
`include "bimodal_gshare_branch_predictor_top_macros.svh"
module bgp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bgp_pkg::t_req i_req,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output bgp_pkg::t_req o_head
);
    import bgp_pkg::*;

    t_req              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    `BGP_ASSERT_NOW(a_no_push_full, i_push, !o_full, "push into full queue")
    `BGP_ASSERT_NOW(a_no_pop_empty, i_pop, !o_empty, "pop from empty queue")
    `BGP_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + QCNT_W'(1), "queue count did not grow on push")

endmodule

FILE: src/bgp_back.sv
// back end: counter table read-modify-write with bypass, counts, output register
// depends on bgp_pkg and the assertion macro header
`include "bimodal_gshare_branch_predictor_top_macros.svh"
module bgp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  bgp_pkg::t_req    i_q_head,
    output logic             o_pop,
    output logic             o_clearing,
    output logic             o_valid,
    input  logic             i_ready,
    output bgp_pkg::t_result o_result
);
    import bgp_pkg::*;

    t_ctr             r_table [TABLE_DEPTH];
    t_ctr             r_mem_q;
    logic             r_clr_busy;
    t_idx             r_clr_addr;

    logic             r_rd_vld;
    t_req             r_rd;
    logic             r_byp;
    t_ctr             r_byp_val;

    logic [CNT_W-1:0] r_branches;
    logic [CNT_W-1:0] r_misses;
    logic [CNT_W-1:0] n_branches;
    logic [CNT_W-1:0] n_misses;

    logic             r_out_vld;
    t_result          r_out;

    logic             issue;
    logic             e_fire;
    t_ctr             ctr;
    t_ctr             n_ctr;
    logic             pred;
    logic             miss;
    logic             wr_en;
    t_idx             wr_addr;
    t_ctr             wr_data;

    assign e_fire = r_rd_vld && (!r_out_vld || i_ready);
    assign issue  = !i_q_empty && !r_clr_busy && (!r_rd_vld || e_fire);
    assign o_pop  = issue;

    always_comb begin
        ctr  = r_byp ? r_byp_val : r_mem_q;
        pred = (ctr >= CTR_WEAK_TAKEN);
        miss = (pred != r_rd.taken);
        if (r_rd.taken) begin
            n_ctr = (ctr == CTR_MAX) ? ctr : ctr + t_ctr'(1);
        end else begin
            n_ctr = (ctr == '0) ? ctr : ctr - t_ctr'(1);
        end
        n_branches = (r_branches == '1) ? r_branches : r_branches + CNT_W'(1);
        if (miss && r_misses != '1) begin
            n_misses = r_misses + CNT_W'(1);
        end else begin
            n_misses = r_misses;
        end
        wr_en   = r_clr_busy || e_fire;
        wr_addr = r_clr_busy ? r_clr_addr : r_rd.idx;
        wr_data = r_clr_busy ? CTR_WEAK_TAKEN : n_ctr;
    end

    // simple dual-port style table: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
        if (issue) begin
            r_mem_q <= r_table[i_q_head.idx];
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + t_idx'(1);
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end
    assign o_clearing = r_clr_busy;

    // read stage; the write landing on the same edge as the read is bypassed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (issue) begin
            r_rd_vld <= 1'b1;
        end else if (e_fire) begin
            r_rd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd      <= i_q_head;
            r_byp     <= e_fire && (r_rd.idx == i_q_head.idx);
            r_byp_val <= n_ctr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_branches <= '0;
            r_misses   <= '0;
        end else if (e_fire) begin
            r_branches <= n_branches;
            r_misses   <= n_misses;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (e_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_fire) begin
            r_out.predicted_taken  <= pred;
            r_out.mispredicted     <= miss;
            r_out.table_index      <= r_rd.idx;
            r_out.prediction_count <= n_branches;
            r_out.miss_count       <= n_misses;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    `BGP_ASSERT_NEXT(a_fire_shows, e_fire, r_out_vld, "updated branch did not reach output")
    `BGP_ASSERT_NOW(a_miss_le_seen, 1'b1, r_misses <= r_branches, "miss count above branch count")
    `BGP_ASSERT_NOW(a_no_read_clr, r_clr_busy, !r_rd_vld && !e_fire, "table read during clearing")

endmodule

FILE: src/bimodal_gshare_branch_predictor_top.sv
// Gshare / bimodal branch predictor with 2-bit saturating counters, one resolved
// branch per word. Sustains one word per cycle while the output is ready and no
// clearing sweep runs; a word's result passes a queue slot, then the counter table
// read, then update and output register. The one-write one-read counter table port sets
// that rate; a repeat of the same entry on consecutive words is served by a bypass
// register. After reset all 16384 table entries are swept to weakly taken (one entry
// per cycle), during which no word is accepted; config writes are taken at any time.
module bimodal_gshare_branch_predictor_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bgp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  bgp_pkg::t_cfg                 i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  bgp_pkg::t_branch              i_branch,
    output logic                          o_valid,
    input  logic                          i_ready,
    output bgp_pkg::t_result              o_result
);
    import bgp_pkg::*;

    t_back_status status;
    logic         push;
    t_req         req;
    logic         pop;
    logic         q_empty;
    t_req         q_head;

    bgp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_branch   (i_branch),
        .i_status   (status),
        .o_push     (push),
        .o_req      (req)
    );

    bgp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (req),
        .i_pop   (pop),
        .o_full  (status.q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    bgp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_head   (q_head),
        .o_pop      (pop),
        .o_clearing (status.clearing),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (o_result)
    );

endmodule
